>>> sv/alfp_pkg.sv
package alfp_pkg;

  // Field widths fixed by the interface
  localparam int VALUE_W  = 16;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [KIND_W-1:0]         kind_t;
  typedef logic [STATUS_W-1:0]       status_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // Operation codes
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_APPEND = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;
  localparam kind_t KIND_SEARCH = 2'd3;

  // Status codes
  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_MISS = 2'd2;

  // Value reported for head/tail of an empty list
  localparam value_t EMPTY_VALUE = -16'sd1;

endpackage

>>> sv/alfp_node_mem.sv
module alfp_node_mem #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [$clog2(DEPTH)-1:0]              rd_addr,
  output alfp_pkg::value_t                      rd_item,
  output logic [$clog2(DEPTH+1)-1:0]            rd_link,
  input  logic                                  item_we,
  input  logic                                  link_we,
  input  logic [$clog2(DEPTH)-1:0]              wr_addr,
  input  alfp_pkg::value_t                      wr_item,
  input  logic [$clog2(DEPTH+1)-1:0]            wr_link
);
  import alfp_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  value_t        item_mem [DEPTH];
  logic [LW-1:0] link_mem [DEPTH];

  // Fill mark: entries at or above it were never written, and their link
  // reads as the next index (the last one reads as null).
  logic [LW-1:0] fill;
  logic [LW-1:0] link_q;
  logic [IW-1:0] rd_addr_q;
  logic          fresh_q;

  // Write port
  always_ff @(posedge clk) begin
    if (item_we) item_mem[wr_addr] <= wr_item;
    if (link_we) link_mem[wr_addr] <= wr_link;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_item   <= item_mem[rd_addr];
      link_q    <= link_mem[rd_addr];
      rd_addr_q <= rd_addr;
      fresh_q   <= (LW'(rd_addr) >= fill);
    end
  end

  // Nodes are first written strictly in index order
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (link_we && (LW'(wr_addr) == fill)) begin
      fill <= fill + LW'(1);
    end
  end

  assign rd_link = fresh_q ? (LW'(rd_addr_q) + LW'(1)) : link_q;

endmodule

>>> sv/array_linked_list_free_pool_core.sv
// A full pool, or a search or remove on an empty list, goes straight to S_RESP; insert passes
// S_ALLOC; append S_ALLOC, then S_APPEND on a non-empty list; search and remove walk S_WALK
// over at most CAPACITY nodes, a remove hit then S_UNLINK, and S_HEADRD when the head goes
// and a node remains. The walk visits one node per cycle, set by the single read port of the
// node memory. One item in flight; the next beat is taken the cycle after the result is
// registered. Reset (synchronous) empties the list and clears the fill mark; no clearing pass.
module array_linked_list_free_pool_core #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  alfp_pkg::kind_t   kind,
  input  alfp_pkg::value_t  value,
  output logic              out_valid,
  input  logic              out_ready,
  output alfp_pkg::status_t status,
  output logic              found,
  output alfp_pkg::value_t  first_value,
  output alfp_pkg::value_t  last_value,
  output alfp_pkg::count_t  count,
  output logic              is_empty
);
  import alfp_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY+1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALLOC  = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_UNLINK = 3'd4;
  localparam logic [2:0] S_HEADRD = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]    state;
  logic [LW-1:0] head, tail, free, cnt;
  logic [LW-1:0] cur, prev, nxt, steps;
  value_t        first_v, last_v, prev_item, value_q;
  kind_t         kind_q;
  status_t       status_q;
  logic          found_q;

  // Memory port signals
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  value_t        rd_item;
  logic [LW-1:0] rd_link;
  logic          item_we, link_we;
  logic [IW-1:0] wr_addr;
  value_t        wr_item;
  logic [LW-1:0] wr_link;

  logic accept, full, head_ok, tail_ok, prev_ok, link_ok, hit, more;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign head_ok  = (head < NIL);
  assign tail_ok  = (tail < NIL);
  assign prev_ok  = (prev < NIL);
  assign link_ok  = (rd_link < NIL);
  assign full     = (cnt >= NIL) || !(free < NIL);
  assign hit      = (rd_item == value_q);
  assign more     = link_ok && ((steps + LW'(1)) < NIL);

  alfp_node_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_item (rd_item),
    .rd_link (rd_link),
    .item_we (item_we),
    .link_we (link_we),
    .wr_addr (wr_addr),
    .wr_item (wr_item),
    .wr_link (wr_link)
  );

  // Memory requests for each step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    item_we = 1'b0;
    link_we = 1'b0;
    wr_addr = '0;
    wr_item = value_q;
    wr_link = NIL;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_INSERT || kind == KIND_APPEND) begin
            rd_en   = !full;
            rd_addr = free[IW-1:0];
          end else begin
            rd_en   = head_ok;
            rd_addr = head[IW-1:0];
          end
        end
      end
      S_ALLOC: begin
        item_we = 1'b1;
        link_we = 1'b1;
        wr_addr = cur[IW-1:0];
        wr_link = (kind_q == KIND_INSERT) ? head : NIL;
      end
      S_APPEND: begin
        link_we = 1'b1;
        wr_addr = tail[IW-1:0];
        wr_link = cur;
      end
      S_WALK: begin
        if (hit) begin
          // bypass the matched node
          link_we = (kind_q == KIND_REMOVE) && prev_ok;
          wr_addr = prev[IW-1:0];
          wr_link = rd_link;
        end else begin
          rd_en   = more;
          rd_addr = rd_link[IW-1:0];
        end
      end
      S_UNLINK: begin
        // push node onto the free list; fetch new head item if needed
        link_we = 1'b1;
        wr_addr = cur[IW-1:0];
        wr_link = free;
        rd_en   = !prev_ok && (nxt < NIL);
        rd_addr = nxt[IW-1:0];
      end
      S_HEADRD, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control sequence and list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      tail      <= NIL;
      free      <= '0;
      cnt       <= '0;
      first_v   <= EMPTY_VALUE;
      last_v    <= EMPTY_VALUE;
      out_valid <= 1'b0;
    end else begin
      // result beat taken; S_RESP sets valid itself
      if (out_valid && out_ready && (state != S_RESP)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q   <= kind;
            value_q  <= value;
            found_q  <= 1'b0;
            status_q <= ST_DONE;
            if (kind == KIND_INSERT || kind == KIND_APPEND) begin
              if (full) begin
                status_q <= ST_FULL;
                state    <= S_RESP;
              end else begin
                cur   <= free;
                state <= S_ALLOC;
              end
            end else if (!head_ok) begin
              status_q <= ST_MISS;
              state    <= S_RESP;
            end else begin
              cur   <= head;
              prev  <= NIL;
              steps <= '0;
              state <= S_WALK;
            end
          end
        end
        S_ALLOC: begin
          free <= rd_link;
          cnt  <= cnt + LW'(1);
          if (kind_q == KIND_INSERT) begin
            head    <= cur;
            first_v <= value_q;
            if (!head_ok) begin
              tail   <= cur;
              last_v <= value_q;
            end
            state <= S_RESP;
          end else if (!tail_ok) begin
            head    <= cur;
            first_v <= value_q;
            tail    <= cur;
            last_v  <= value_q;
            state   <= S_RESP;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          tail   <= cur;
          last_v <= value_q;
          state  <= S_RESP;
        end
        S_WALK: begin
          if (hit) begin
            found_q <= 1'b1;
            if (kind_q == KIND_SEARCH) begin
              state <= S_RESP;
            end else begin
              nxt <= rd_link;
              cnt <= cnt - LW'(1);
              if (!prev_ok) head <= rd_link;
              if (cur == tail) begin
                tail   <= prev;
                last_v <= prev_ok ? prev_item : EMPTY_VALUE;
              end
              state <= S_UNLINK;
            end
          end else begin
            prev      <= cur;
            prev_item <= rd_item;
            steps     <= steps + LW'(1);
            if (more) begin
              cur <= rd_link;
            end else begin
              status_q <= ST_MISS;
              state    <= S_RESP;
            end
          end
        end
        S_UNLINK: begin
          free <= cur;
          if (!prev_ok && (nxt < NIL)) begin
            state <= S_HEADRD;
          end else begin
            if (!prev_ok) first_v <= EMPTY_VALUE;
            state <= S_RESP;
          end
        end
        S_HEADRD: begin
          first_v <= rd_item;
          state   <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= status_q;
            found       <= found_q;
            first_value <= first_v;
            last_value  <= last_v;
            count       <= COUNT_W'(cnt);
            is_empty    <= !head_ok;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
